/* design/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Antecedent and consequent joined by an overlapping implication.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

/* design/rtdp_pkg.sv */
package rtdp_pkg;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FORMAT   = 3'd1,
		ST_NONDIGIT = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_LEADZERO = 3'd4,
		ST_RANGE    = 3'd5
	} status_t;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_END   = 8'h00;

	localparam logic [1:0] CHAN_RED   = 2'd0;
	localparam logic [1:0] CHAN_BLUE  = 2'd2;

	localparam logic [8:0]  CH_MAX  = 9'd255;
	localparam logic [8:0]  ACC_SAT = 9'd256;

	typedef struct packed {
		logic [1:0] chan;
		logic [8:0] acc;
		logic       digits;
		logic       lead_zero;
		status_t    err;
		logic [7:0] red_hold;
		logic [7:0] green_hold;
	} parse_state_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		status_t    status;
	} rgb_result_t;

	localparam parse_state_t STATE_RESET = '{
		chan:       CHAN_RED,
		acc:        9'd0,
		digits:     1'b0,
		lead_zero:  1'b0,
		err:        ST_OK,
		red_hold:   8'd0,
		green_hold: 8'd0
	};

endpackage

/* design/rtdp_char_if.sv */
interface rtdp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;

	modport source (output valid, output char_in, input ready);
	modport sink (input valid, input char_in, output ready);
endinterface

/* design/rtdp_rgb_if.sv */
interface rtdp_rgb_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [2:0] status;

	modport source (output valid, output red, output green, output blue, output status,
		input ready);
	modport sink (input valid, input red, input green, input blue, input status,
		output ready);
endinterface

/* design/rtdp_step.sv */
// Next-state and result logic for one character.
module rtdp_step (
	input  rtdp_pkg::parse_state_t cur,
	input  logic [7:0]             char_in,
	output rtdp_pkg::parse_state_t nxt,
	output logic                   emit,
	output rtdp_pkg::rgb_result_t  res
);

	logic        is_digit;
	logic [3:0]  digit;
	logic [11:0] acc_mul;
	logic        last;
	rtdp_pkg::parse_state_t upd;

	assign is_digit = (char_in >= rtdp_pkg::CHAR_ZERO) && (char_in <= rtdp_pkg::CHAR_NINE);
	assign digit    = 4'(char_in - rtdp_pkg::CHAR_ZERO);
	assign acc_mul  = ({3'd0, cur.acc} << 3) + ({3'd0, cur.acc} << 1) + {8'd0, digit};
	assign last     = cur.chan >= rtdp_pkg::CHAN_BLUE;
	assign emit     = char_in == rtdp_pkg::CHAR_END;

	always_comb begin
		upd = cur;
		if (cur.err == rtdp_pkg::ST_OK) begin
			priority if (is_digit) begin
				if (cur.digits && cur.lead_zero) begin
					upd.err = rtdp_pkg::ST_LEADZERO;
				end else begin
					if (!cur.digits && digit == 4'd0) begin
						upd.lead_zero = 1'b1;
					end
					upd.digits = 1'b1;
					upd.acc = (acc_mul > {3'd0, rtdp_pkg::ACC_SAT}) ? rtdp_pkg::ACC_SAT
						: acc_mul[8:0];
				end
			end else if (!cur.digits) begin
				upd.err = (char_in == rtdp_pkg::CHAR_COMMA || char_in == rtdp_pkg::CHAR_END)
					? rtdp_pkg::ST_EMPTY : rtdp_pkg::ST_NONDIGIT;
			end else if (cur.acc > rtdp_pkg::CH_MAX) begin
				upd.err = rtdp_pkg::ST_RANGE;
			end else if (char_in == rtdp_pkg::CHAR_COMMA) begin
				if (last) begin
					upd.err = rtdp_pkg::ST_FORMAT;
				end else begin
					if (cur.chan == rtdp_pkg::CHAN_RED) begin
						upd.red_hold = cur.acc[7:0];
					end else begin
						upd.green_hold = cur.acc[7:0];
					end
					upd.chan      = cur.chan + 2'd1;
					upd.acc       = 9'd0;
					upd.digits    = 1'b0;
					upd.lead_zero = 1'b0;
				end
			end else if (char_in == rtdp_pkg::CHAR_END) begin
				if (!last) begin
					upd.err = rtdp_pkg::ST_FORMAT;
				end
			end else begin
				upd.err = rtdp_pkg::ST_NONDIGIT;
			end
		end

		if (upd.err == rtdp_pkg::ST_OK) begin
			res.red    = upd.red_hold;
			res.green  = upd.green_hold;
			res.blue   = upd.acc[7:0];
			res.status = rtdp_pkg::ST_OK;
		end else begin
			res.red    = 8'd0;
			res.green  = 8'd0;
			res.blue   = 8'd0;
			res.status = upd.err;
		end

		nxt = emit ? rtdp_pkg::STATE_RESET : upd;
	end

endmodule

/* design/rgb_triple_decimal_parser.sv */
// A transferred character waits in the input register and is then applied to the parse state;
// a result it causes is held in the output register, from which it can transfer.
// Throughput: one character per cycle; only a terminator waits, while the previous result
// is still held on the output.
// Reset: arst_n clears the parse state, the input valid and the output valid at once.
module rgb_triple_decimal_parser (
	input logic        clk,
	input logic        arst_n,
	rtdp_char_if.sink  chars,
	rtdp_rgb_if.source colour
);

	// Input register: the character waiting to be applied to the parse state.
	logic       valid_s1;
	logic [7:0] char_s1;

	// Parse state: channel index, accumulator, flags, first error and held channels.
	rtdp_pkg::parse_state_t state_q;

	// Result register towards the output channel.
	logic                  out_valid_q;
	rtdp_pkg::rgb_result_t out_q;

	rtdp_pkg::parse_state_t state_nxt;
	rtdp_pkg::rgb_result_t  res;
	logic                   emit;
	logic                   advance_s1;

	rtdp_step u_step (
		.cur     (state_q),
		.char_in (char_s1),
		.nxt     (state_nxt),
		.emit    (emit),
		.res     (res)
	);

	// A character that yields no result always moves on. The terminator needs the result
	// register free, or being emptied by a transfer in the same cycle.
	assign advance_s1  = valid_s1 && (!emit || !out_valid_q || colour.ready);
	assign chars.ready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.char_in;
		end
	end

	// The state update happens only as the registered character is consumed; the terminator
	// returns the state to its reset value inside the step logic.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rtdp_pkg::STATE_RESET;
		end else if (advance_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && emit) begin
			out_valid_q <= 1'b1;
		end else if (colour.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && emit) begin
			out_q <= res;
		end
	end

	assign colour.valid  = out_valid_q;
	assign colour.red    = out_q.red;
	assign colour.green  = out_q.green;
	assign colour.blue   = out_q.blue;
	assign colour.status = out_q.status;

endmodule

/* design/rtdp_checker.sv */
`include "assert_macros.svh"

module rtdp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue,
	input logic [2:0] status
);

	// An errored result carries zero channels.
	`ASSERT_IMPLY(a_err_zero, clk, arst_n, out_valid && status != rtdp_pkg::ST_OK, red == 8'd0 && green == 8'd0 && blue == 8'd0)

	// The input side only stalls while a finished result is itself stalled.
	`ASSERT_IMPLY(a_stall_cause, clk, arst_n, !in_ready, out_valid && !out_ready)

	// No result is shown in the first cycle after reset is released.
	`ASSERT_IMPLY(a_reset_quiet, clk, arst_n, !$past(arst_n), !out_valid)

	// A stalled result holds its value.
	`ASSERT_IMPLY(a_out_hold, clk, arst_n, $past(out_valid && !out_ready) && $past(arst_n), out_valid && $stable({red, green, blue, status}))

	// No result appears without a character behind it.
	`ASSERT_IMPLY(a_no_invent, clk, arst_n, $rose(out_valid), $past(in_valid && in_ready, 2) || !$past(in_ready) || $past(in_valid && in_ready, 3) || $past(out_valid))

endmodule

bind rgb_triple_decimal_parser rtdp_checker u_rtdp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (chars.valid),
	.in_ready  (chars.ready),
	.out_valid (colour.valid),
	.out_ready (colour.ready),
	.red       (colour.red),
	.green     (colour.green),
	.blue      (colour.blue),
	.status    (colour.status)
);

/* sim/rgb_parse_checker.sv */
module rgb_parse_checker (
	input  logic        clk,
	input  logic        arst_n,
	rtdp_char_if        chars,
	rtdp_rgb_if         colour,
	output int unsigned mismatches,
	output int unsigned results_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import rtdp_pkg::*;

	// Printing stops after this many lines; the count still goes on.
	localparam int unsigned PRINT_LIMIT = 100;

	parse_state_t parse_st = STATE_RESET;
	rgb_result_t  colour_expected_q[$];

	initial begin
		mismatches      = 0;
		results_pending = 0;
	end

	task automatic report_mismatch(input string msg);
		if (mismatches < PRINT_LIMIT)
			$display("[%0t] colour mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// Advances the parse state by one character and queues the colour that a
	// terminator produces.
	task automatic parse_char(input logic [7:0] ch);
		logic        last;
		logic [3:0]  digit;
		logic [11:0] sum;
		rgb_result_t res;
		last = (parse_st.chan >= CHAN_BLUE);
		if (parse_st.err == ST_OK) begin
			if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
				digit = 4'(ch - CHAR_ZERO);
				if (parse_st.digits && parse_st.lead_zero) begin
					parse_st.err = ST_LEADZERO;
				end else begin
					if (!parse_st.digits && digit == 4'd0)
						parse_st.lead_zero = 1'b1;
					parse_st.digits = 1'b1;
					sum = 12'(parse_st.acc) * 12'd10 + 12'(digit);
					parse_st.acc = (sum > 12'(ACC_SAT)) ? ACC_SAT : sum[8:0];
				end
			end else if (!parse_st.digits) begin
				if (ch == CHAR_COMMA || ch == CHAR_END)
					parse_st.err = ST_EMPTY;
				else
					parse_st.err = ST_NONDIGIT;
			end else if (parse_st.acc > CH_MAX) begin
				parse_st.err = ST_RANGE;
			end else if (ch == CHAR_COMMA) begin
				if (last) begin
					parse_st.err = ST_FORMAT;
				end else begin
					if (parse_st.chan == CHAN_RED)
						parse_st.red_hold = parse_st.acc[7:0];
					else
						parse_st.green_hold = parse_st.acc[7:0];
					parse_st.chan      = parse_st.chan + 2'd1;
					parse_st.acc       = 9'd0;
					parse_st.digits    = 1'b0;
					parse_st.lead_zero = 1'b0;
				end
			end else if (ch == CHAR_END) begin
				if (!last)
					parse_st.err = ST_FORMAT;
			end else begin
				parse_st.err = ST_NONDIGIT;
			end
		end
		if (ch == CHAR_END) begin
			if (parse_st.err == ST_OK)
				res = '{red: parse_st.red_hold, green: parse_st.green_hold,
					blue: parse_st.acc[7:0], status: ST_OK};
			else
				res = '{red: 8'd0, green: 8'd0, blue: 8'd0, status: parse_st.err};
			colour_expected_q.push_back(res);
			parse_st = STATE_RESET;
		end
	endtask

	always @(posedge clk) begin
		rgb_result_t exp_res;
		if (!arst_n) begin
			parse_st = STATE_RESET;
			colour_expected_q.delete();
		end else begin
			// A colour only leaves after its terminator has passed the block's registers,
			// so checking before predicting loses nothing.
			if (colour.valid && colour.ready) begin
				if (colour_expected_q.size() == 0) begin
					report_mismatch("colour transferred with none expected");
				end else begin
					exp_res = colour_expected_q.pop_front();
					if (colour.red !== exp_res.red)
						report_mismatch($sformatf("red got %0d, expected %0d",
							colour.red, exp_res.red));
					if (colour.green !== exp_res.green)
						report_mismatch($sformatf("green got %0d, expected %0d",
							colour.green, exp_res.green));
					if (colour.blue !== exp_res.blue)
						report_mismatch($sformatf("blue got %0d, expected %0d",
							colour.blue, exp_res.blue));
					if (colour.status !== exp_res.status)
						report_mismatch($sformatf("status got %0d, expected %0d",
							colour.status, exp_res.status));
				end
			end
			if (chars.valid && chars.ready)
				parse_char(chars.char_in);
		end
		results_pending <= colour_expected_q.size();
	end

endmodule

/* sim/rgb_triple_decimal_parser_tb.sv */
module rgb_triple_decimal_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rtdp_pkg::*;

	// Number of characters in the random part of the run.
	localparam int unsigned RANDOM_CHARS    = 1150;
	// Length of the stretch in which the colour side refuses every transfer.
	localparam int unsigned HOLD_OFF_CYCLES = 300;
	// Cycles without any transfer before the run is declared hung. This is
	// well above the hold-off and any plausible run of random stalls.
	localparam int unsigned WATCHDOG_LIMIT  = 2000;
	// Settling time once nothing is expected.
	localparam int unsigned DRAIN_CYCLES    = 10;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        hold_off;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned mismatch_count;
	int unsigned results_pending;
	int unsigned quiet_cycles;
	int unsigned random_chars;
	logic [7:0]  text_q[$];

	rtdp_char_if chars_if ();
	rtdp_rgb_if  colour_if ();

	rgb_triple_decimal_parser i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.colour (colour_if)
	);

	// The checker watches both channels, predicts every colour and hands back
	// its mismatch count; this module only drives stimulus and decides.
	rgb_parse_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.chars           (chars_if),
		.colour          (colour_if),
		.mismatches      (mismatch_count),
		.results_pending (results_pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The colour side changes ready only at the falling edge. While the
	// hold-off is active it refuses everything, so the block's output register
	// fills and it must stop taking characters.
	always @(negedge clk) begin
		colour_if.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
	end

	// Any cycle without a transfer on either channel counts towards a hang.
	always @(posedge clk) begin
		if (!arst_n || (chars_if.valid && chars_if.ready) ||
				(colour_if.valid && colour_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("rgb_triple_decimal_parser_tb: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offers one character from a falling edge and returns at the falling edge
	// after its transfer. Idle cycles before it carry junk with valid low, and
	// valid is never dropped and raised again in the same step.
	task automatic send_char(input logic [7:0] ch);
		while ($urandom_range(99) < send_idle_pct) begin
			chars_if.valid   <= 1'b0;
			chars_if.char_in <= 8'($urandom_range(255));
			@(negedge clk);
		end
		chars_if.valid   <= 1'b1;
		chars_if.char_in <= ch;
		@(posedge clk);
		while (!chars_if.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_text();
		foreach (text_q[i])
			send_char(text_q[i]);
	endtask

	// Sends a string literal followed by its terminating zero byte.
	task automatic send_literal(input string s);
		text_q.delete();
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
		text_q.push_back(CHAR_END);
		send_text();
	endtask

	// Changes how often each side idles. Valid is dropped first so the last
	// character is not transferred twice, and the new rates take effect at a
	// rising edge so the ready process never races the change.
	task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
		chars_if.valid <= 1'b0;
		@(posedge clk);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		@(negedge clk);
	endtask

	task automatic hold_results();
		@(posedge clk);
		hold_off = 1'b1;
		repeat (HOLD_OFF_CYCLES)
			@(posedge clk);
		hold_off = 1'b0;
	endtask

	// Appends the decimal digits of a value, most significant first.
	task automatic add_number(input int unsigned val);
		int unsigned place;
		place = 1;
		while (place * 10 <= val)
			place *= 10;
		while (place > 0) begin
			text_q.push_back(CHAR_ZERO + 8'(val / place));
			val   %= place;
			place /= 10;
		end
	endtask

	// One channel's text. Most are legal values; the rest aim at the range
	// check (including saturation of long numbers), leading zeros and empty
	// channels.
	task automatic add_channel();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 62) begin
			add_number($urandom_range(255));
		end else if (pick < 70) begin
			add_number($urandom_range(1) ? 255 : 0);
		end else if (pick < 78) begin
			add_number($urandom_range(9));
		end else if (pick < 85) begin
			add_number($urandom_range(999, 256));
		end else if (pick < 88) begin
			add_number($urandom_range(99999, 1000));
		end else if (pick < 95) begin
			text_q.push_back(CHAR_ZERO);
			add_number($urandom_range(99));
		end
		// Otherwise the channel is left empty.
	endtask

	task automatic noise_char();
		int unsigned pick;
		pick = $urandom_range(9);
		if (pick < 4)
			text_q.push_back(CHAR_ZERO + 8'($urandom_range(9)));
		else if (pick < 6)
			text_q.push_back(CHAR_COMMA);
		else
			text_q.push_back(8'($urandom_range(255)));
	endtask

	// Builds one colour string into text_q. Three quarters are shaped like
	// "R,G,B", mostly with three channels and now and then with one byte
	// overwritten; the rest are short runs of digits, commas and junk.
	task automatic build_colour_text();
		int unsigned shape;
		int unsigned count_pick;
		int unsigned n_channels;
		text_q.delete();
		shape = $urandom_range(99);
		if (shape < 75) begin
			count_pick = $urandom_range(19);
			case (count_pick)
				0:       n_channels = 1;
				1:       n_channels = 2;
				2:       n_channels = 4;
				default: n_channels = 3;
			endcase
			for (int i = 0; i < n_channels; i++) begin
				if (i != 0)
					text_q.push_back(CHAR_COMMA);
				add_channel();
			end
			if ($urandom_range(9) == 0 && text_q.size() != 0)
				text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(255, 1));
		end else begin
			repeat ($urandom_range(8))
				noise_char();
		end
		text_q.push_back(CHAR_END);
	endtask

	initial begin
		int unsigned phase;
		arst_n           = 1'b0;
		hold_off         = 1'b0;
		send_idle_pct    = 0;
		recv_idle_pct    = 0;
		quiet_cycles     = 0;
		random_chars     = 0;
		phase            = 0;
		chars_if.valid   = 1'b0;
		chars_if.char_in = 8'd0;
		colour_if.ready  = 1'b0;

		repeat (6)
			@(negedge clk);
		arst_n <= 1'b1;

		// First stretch: the sender idles now and then, the receiver more often.
		set_idling(34, 58);

		// Directed strings: channel extremes, then at least one string per error status code.
		// The strings with a range fault or a comma after blue carry bytes
		// after the fault, which must not change the reported error.
		send_literal("255,0,9");
		send_literal("");
		send_literal(",");
		send_literal("1,2");
		send_literal("0,0,0,x");
		send_literal("256,1");
		send_literal("00");
		send_literal("12a");
		text_q = '{CHAR_ZERO + 8'd1, CHAR_COMMA, 8'hFF, CHAR_END};
		send_text();

		// Random strings in three stretches of idling; the last stretch has
		// no idling at all apart from one long hold-off on the colour side.
		while (random_chars < RANDOM_CHARS) begin
			if (phase == 0 && random_chars >= RANDOM_CHARS / 3) begin
				set_idling(58, 34);
				phase = 1;
			end else if (phase == 1 && random_chars >= 2 * RANDOM_CHARS / 3) begin
				set_idling(0, 0);
				fork
					hold_results();
				join_none
				phase = 2;
			end
			build_colour_text();
			send_text();
			random_chars += text_q.size();
		end
		chars_if.valid <= 1'b0;

		// Wait for every expected colour, then give the block time to show
		// anything it should not.
		while (results_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		if (mismatch_count == 0)
			$display("rgb_triple_decimal_parser_tb: done, clean");
		else
			$display("rgb_triple_decimal_parser_tb: done, errors");
		$finish;
	end

endmodule

/* sim.f */
+incdir+design
design/rtdp_pkg.sv
design/rtdp_char_if.sv
design/rtdp_rgb_if.sv
design/rtdp_step.sv
design/rgb_triple_decimal_parser.sv
design/rtdp_checker.sv
sim/rgb_parse_checker.sv
sim/rgb_triple_decimal_parser_tb.sv
